// ===== src/sfrwp_pkg.sv =====
package sfrwp_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 16;
    localparam int IDX_W         = 7;
    localparam int WIN_LEN       = 10;
    localparam int FILL_W        = 4;
    localparam int REG_COUNT_DEF = 128;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic [IDX_W-1:0]  read_index;
    } req_t;

    typedef struct packed {
        logic                     frame_ok;
        logic                     checksum_bad;
        logic [IDX_W-1:0]         frame_index;
        logic signed [WORD_W-1:0] read_value;
    } rsp_t;

    // write pair from a good frame: d0 goes to idx, d1 to idx+1 (mod 128)
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] d0;
        logic [WORD_W-1:0] d1;
    } wr_req_t;

endpackage

// ===== src/sync_framed_register_write_parser.sv =====
// Channel | Dir | Handshake                 | Payload
// req     | in  | req_valid / req_stall     | sfrwp_pkg::req_t  (rx_byte, read_index)
// rsp     | out | rsp_valid / rsp_stall     | sfrwp_pkg::rsp_t  (flags, frame_index, read_value)
//
// One word per cycle sustained while rsp is not stalled; an accepted word enters the input register,
// then frame check and register file write/read load the result stage that drives rsp.
// Register file read data comes from the banked memory's registered read port.
// Reset empties the window and marks all registers as zero through per-entry valid bits.
// rsp_stall holds the result stage; req_stall rises only when both stages are full.
module sync_framed_register_write_parser #(
    parameter int REG_COUNT = sfrwp_pkg::REG_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  sfrwp_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output sfrwp_pkg::rsp_t  rsp
);

    localparam int BW = sfrwp_pkg::BYTE_W;
    localparam int WW = sfrwp_pkg::WORD_W;
    localparam int FW = sfrwp_pkg::FILL_W;
    localparam int WL = sfrwp_pkg::WIN_LEN;

    logic             in_vld_reg;
    sfrwp_pkg::req_t  in_data_reg;
    logic             advance;

    logic [BW-1:0]    win_reg  [WL];
    logic [BW-1:0]    win_next [WL];
    logic [BW-1:0]    win_ins  [WL];
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic [FW-1:0]    fill_eff;

    logic             full;
    logic             sync_ok;
    logic [WW-1:0]    addr_w;
    logic [WW-1:0]    d0_w;
    logic [WW-1:0]    d1_w;
    logic [WW-1:0]    chk_w;
    logic [WW-1:0]    sum_w;
    logic             frame_hit;
    logic             csum_bad;
    logic [sfrwp_pkg::IDX_W-1:0] frame_idx;

    logic             res_vld_reg;
    logic             ok_reg;
    logic             bad_reg;
    logic [sfrwp_pkg::IDX_W-1:0] fidx_reg;

    sfrwp_pkg::wr_req_t wr;
    logic [WW-1:0]    rd_word;

    assign advance   = in_vld_reg && (!res_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_data_reg <= req;
        end
    end

    // drop the new byte into the window at the fill position
    always_comb
    begin
        fill_eff = (fill_reg >= FW'(WL)) ? FW'(WL - 1) : fill_reg;
        for (int i = 0; i < WL; i++)
        begin
            win_ins[i] = (fill_eff == FW'(i)) ? in_data_reg.rx_byte : win_reg[i];
        end
    end

    assign full    = (fill_eff == FW'(WL - 1));
    assign sync_ok = (win_ins[0] == sfrwp_pkg::SYNC_BYTE) && (win_ins[1] == sfrwp_pkg::SYNC_BYTE);
    assign addr_w  = {win_ins[2], win_ins[3]};
    assign d0_w    = {win_ins[4], win_ins[5]};
    assign d1_w    = {win_ins[6], win_ins[7]};
    assign chk_w   = {win_ins[8], win_ins[9]};
    assign sum_w   = WW'(addr_w + d0_w + d1_w);

    assign frame_hit = full && sync_ok && (sum_w == chk_w);
    assign csum_bad  = full && sync_ok && (sum_w != chk_w);
    assign frame_idx = win_ins[3][sfrwp_pkg::IDX_W-1:0];

    always_comb
    begin
        if (full && !frame_hit)
        begin
            // shift out the oldest byte; last slot keeps its byte until overwritten
            for (int i = 0; i < WL - 1; i++)
            begin
                win_next[i] = win_ins[i + 1];
            end
            win_next[WL-1] = win_ins[WL-1];
            fill_next      = FW'(WL - 1);
        end
        else
        begin
            for (int i = 0; i < WL; i++)
            begin
                win_next[i] = win_ins[i];
            end
            fill_next = frame_hit ? '0 : fill_eff + FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < WL; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                fill_reg <= fill_next;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok_reg   <= frame_hit;
            bad_reg  <= csum_bad;
            fidx_reg <= frame_hit ? frame_idx : '0;
        end
    end

    assign wr.en  = advance && frame_hit;
    assign wr.idx = frame_idx;
    assign wr.d0  = d0_w;
    assign wr.d1  = d1_w;

    sfrwp_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .re    (advance),
        .raddr (in_data_reg.read_index),
        .rdata (rd_word)
    );

    assign rsp_valid        = res_vld_reg;
    assign rsp.frame_ok     = ok_reg;
    assign rsp.checksum_bad = bad_reg;
    assign rsp.frame_index  = fidx_reg;
    assign rsp.read_value   = $signed(rd_word);

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WL - 1))
        else $error("window fill count out of range");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.frame_ok && rsp.checksum_bad))
        else $error("frame_ok and checksum_bad both set");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.frame_ok |-> rsp.frame_index == '0)
        else $error("frame_index nonzero without a good frame");

    a_empty_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_hit |=> fill_reg == '0)
        else $error("window not emptied after good frame");

endmodule

// ===== src/sfrwp_regfile.sv =====
module sfrwp_regfile #(
    parameter int REG_COUNT = sfrwp_pkg::REG_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sfrwp_pkg::wr_req_t                 wr,
    input  logic                               re,
    input  logic [sfrwp_pkg::IDX_W-1:0]        raddr,
    output logic [sfrwp_pkg::WORD_W-1:0]       rdata
);

    // even and odd banks: idx and idx+1 always differ in parity, so each
    // bank sees at most one write per cycle
    localparam int BANK_DEPTH = (REG_COUNT + 1) / 2;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [sfrwp_pkg::WORD_W-1:0] ev_mem [BANK_DEPTH];
    logic [sfrwp_pkg::WORD_W-1:0] od_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0]        ev_vld_reg;
    logic [BANK_DEPTH-1:0]        od_vld_reg;

    logic [sfrwp_pkg::IDX_W-1:0]  idx0;
    logic [sfrwp_pkg::IDX_W-1:0]  idx1;
    logic                         in0;
    logic                         in1;
    logic [sfrwp_pkg::IDX_W-1:0]  ev_idx;
    logic [sfrwp_pkg::IDX_W-1:0]  od_idx;
    logic [sfrwp_pkg::WORD_W-1:0] ev_d;
    logic [sfrwp_pkg::WORD_W-1:0] od_d;
    logic                         ev_en;
    logic                         od_en;
    logic [BA_W-1:0]              ev_addr;
    logic [BA_W-1:0]              od_addr;
    logic [BA_W-1:0]              rd_addr;
    logic                         rd_in;
    logic                         hit_ev;
    logic                         hit_od;

    logic [sfrwp_pkg::WORD_W-1:0] ev_rd_reg;
    logic [sfrwp_pkg::WORD_W-1:0] od_rd_reg;
    logic [sfrwp_pkg::WORD_W-1:0] byp_reg;
    logic                         sel_reg;
    logic                         hit_reg;
    logic                         rdvld_reg;

    assign idx0 = wr.idx;
    assign idx1 = wr.idx + 7'd1;
    assign in0  = ({1'b0, idx0} < 8'(REG_COUNT));
    assign in1  = ({1'b0, idx1} < 8'(REG_COUNT));

    assign ev_idx = idx0[0] ? idx1 : idx0;
    assign od_idx = idx0[0] ? idx0 : idx1;
    assign ev_d   = idx0[0] ? wr.d1 : wr.d0;
    assign od_d   = idx0[0] ? wr.d0 : wr.d1;
    assign ev_en  = wr.en && (idx0[0] ? in1 : in0);
    assign od_en  = wr.en && (idx0[0] ? in0 : in1);

    assign ev_addr = ev_idx[BA_W:1];
    assign od_addr = od_idx[BA_W:1];
    assign rd_addr = raddr[BA_W:1];
    assign rd_in   = ({1'b0, raddr} < 8'(REG_COUNT));

    // same-cycle write to the read index wins over the old memory word
    assign hit_ev = ev_en && (raddr == ev_idx);
    assign hit_od = od_en && (raddr == od_idx);

    always_ff @(posedge clk)
    begin
        if (ev_en)
        begin
            ev_mem[ev_addr] <= ev_d;
        end
        if (od_en)
        begin
            od_mem[od_addr] <= od_d;
        end
        if (re)
        begin
            ev_rd_reg <= ev_mem[rd_addr];
            od_rd_reg <= od_mem[rd_addr];
            byp_reg   <= hit_od ? od_d : ev_d;
            sel_reg   <= raddr[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg <= '0;
            od_vld_reg <= '0;
            hit_reg    <= 1'b0;
            rdvld_reg  <= 1'b0;
        end
        else
        begin
            if (ev_en)
            begin
                ev_vld_reg[ev_addr] <= 1'b1;
            end
            if (od_en)
            begin
                od_vld_reg[od_addr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg   <= hit_ev || hit_od;
                rdvld_reg <= rd_in && (raddr[0] ? od_vld_reg[rd_addr] : ev_vld_reg[rd_addr]);
            end
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            rdata = byp_reg;
        end
        else if (!rdvld_reg)
        begin
            rdata = '0;
        end
        else
        begin
            rdata = sel_reg ? od_rd_reg : ev_rd_reg;
        end
    end

    a_ev_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        ev_en |=> ev_vld_reg[$past(ev_addr)])
        else $error("even bank entry not marked valid after write");

    a_od_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        od_en |=> od_vld_reg[$past(od_addr)])
        else $error("odd bank entry not marked valid after write");

    a_bypass_d0: assert property (@(posedge clk) disable iff (!rst_n)
        re && wr.en && in0 && (raddr == wr.idx) |=> rdata == $past(wr.d0))
        else $error("read of freshly written index missed data0");

endmodule

// ===== verif/sfrwp_frame_monitor.sv =====
`timescale 1ns / 1ps

module sfrwp_frame_monitor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  sfrwp_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  sfrwp_pkg::rsp_t rsp,
    output int              errors,
    output int              pending,
    output int              good_frames,
    output int              bad_sums,
    output int              checked
);

    localparam int BYTE_W        = sfrwp_pkg::BYTE_W;
    localparam int WORD_W        = sfrwp_pkg::WORD_W;
    localparam int IDX_W         = sfrwp_pkg::IDX_W;
    localparam int WIN_LEN       = sfrwp_pkg::WIN_LEN;
    localparam int REG_COUNT_DEF = sfrwp_pkg::REG_COUNT_DEF;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = sfrwp_pkg::SYNC_BYTE;

    logic [BYTE_W-1:0] win [WIN_LEN];
    int unsigned       fill;
    logic [WORD_W-1:0] regs [REG_COUNT_DEF];
    sfrwp_pkg::rsp_t   due_rsp_q [$];

    function automatic void slide_window();
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win[i] = win[i + 1];
        end
        fill = WIN_LEN - 1;
    endfunction

    // window/register-file update for one received byte, plus the register readback
    function automatic sfrwp_pkg::rsp_t parse_byte(sfrwp_pkg::req_t w);
        sfrwp_pkg::rsp_t   r;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] d0;
        logic [WORD_W-1:0] d1;
        logic [WORD_W-1:0] chk;
        logic [WORD_W-1:0] sum;
        logic [IDX_W-1:0]  idx_lo;
        logic [IDX_W-1:0]  idx_hi;
        r = '0;
        if (fill >= WIN_LEN)
        begin
            fill = WIN_LEN - 1;
        end
        win[fill] = w.rx_byte;
        fill++;
        if (fill == WIN_LEN)
        begin
            addr = {win[2], win[3]};
            d0   = {win[4], win[5]};
            d1   = {win[6], win[7]};
            chk  = {win[8], win[9]};
            sum  = addr + d0 + d1;
            if (win[0] != SYNC_BYTE || win[1] != SYNC_BYTE)
            begin
                slide_window();
            end
            else if (sum != chk)
            begin
                r.checksum_bad = 1'b1;
                slide_window();
            end
            else
            begin
                idx_lo       = win[3][IDX_W-1:0];
                idx_hi       = idx_lo + 1'b1;  // 127 wraps to 0
                regs[idx_lo] = d0;
                regs[idx_hi] = d1;
                fill          = 0;
                r.frame_ok    = 1'b1;
                r.frame_index = idx_lo;
            end
        end
        r.read_value = regs[w.read_index];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfrwp_pkg::rsp_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win[i] = '0;
            end
            for (int i = 0; i < REG_COUNT_DEF; i++)
            begin
                regs[i] = '0;
            end
            fill = 0;
            due_rsp_q.delete();
            errors      = 0;
            pending     = 0;
            good_frames = 0;
            bad_sums    = 0;
            checked     = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected word on rsp: ok=%0d bad=%0d idx=%0d val=%0d",
                                 rsp.frame_ok, rsp.checksum_bad, rsp.frame_index,
                                 rsp.read_value);
                    end
                end
                else
                begin
                    due = due_rsp_q.pop_front();
                    checked++;
                    if (due.frame_ok)
                    begin
                        good_frames++;
                    end
                    if (due.checksum_bad)
                    begin
                        bad_sums++;
                    end
                    if (rsp !== due)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("rsp mismatch at word %0d: exp ok=%0d bad=%0d idx=%0d val=%0d",
                                     checked, due.frame_ok, due.checksum_bad, due.frame_index,
                                     due.read_value);
                            $display("    got ok=%0d bad=%0d idx=%0d val=%0d",
                                     rsp.frame_ok, rsp.checksum_bad, rsp.frame_index,
                                     rsp.read_value);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                due_rsp_q.push_back(parse_byte(req));
            end
            pending = due_rsp_q.size();
        end
    end

endmodule

// ===== verif/sync_framed_register_write_parser_test.sv =====
`timescale 1ns / 1ps

module sync_framed_register_write_parser_test;

    localparam int BYTE_W = sfrwp_pkg::BYTE_W;
    localparam int WORD_W = sfrwp_pkg::WORD_W;
    localparam int IDX_W  = sfrwp_pkg::IDX_W;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = sfrwp_pkg::SYNC_BYTE;

    localparam int DIRECTED_WORDS = 23;
    localparam int RANDOM_WORDS   = 1000;
    localparam int HOLD_CYCLES    = 48;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    sfrwp_pkg::req_t req;
    logic            rsp_valid;
    logic            rsp_stall;
    sfrwp_pkg::rsp_t rsp;

    int errors;
    int pending;
    int good_frames;
    int bad_sums;
    int checked;

    int               words_sent;
    int               burst_left;
    int               hold_requests;
    logic [IDX_W-1:0] last_add;

    sync_framed_register_write_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sfrwp_frame_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .errors      (errors),
        .pending     (pending),
        .good_frames (good_frames),
        .bad_sums    (bad_sums),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("sync_framed_register_write_parser regression: fail");
        $finish;
    end

    // receiver: random stall modes, plus a long hold-off whenever one is requested
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          holds_done;
        rsp_stall  = 1'b0;
        mode       = STALL_NONE;
        mode_left  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  rsp_stall <= 1'b0;
                    STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                    default:     rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_addr();
        logic [WORD_W-1:0] a;
        a = WORD_W'($urandom);
        case ($urandom_range(0, 3))
            0:       a[IDX_W-1:0] = '1;
            1:       a[IDX_W-1:0] = '0;
            default: ;
        endcase
        return a;
    endfunction

    // bias reads toward the pair the last good frame wrote
    function automatic logic [IDX_W-1:0] pick_read();
        case ($urandom_range(0, 3))
            0:       return last_add;
            1:       return last_add + 1'b1;
            default: return IDX_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [10*BYTE_W-1:0] make_frame(logic [WORD_W-1:0] addr,
                                                        logic [WORD_W-1:0] d0,
                                                        logic [WORD_W-1:0] d1,
                                                        bit corrupt);
        logic [WORD_W-1:0] chk;
        chk = addr + d0 + d1;
        if (corrupt)
        begin
            chk = chk ^ (16'h0001 << $urandom_range(0, 15));
        end
        return {SYNC_BYTE, SYNC_BYTE, addr, d0, d1, chk};
    endfunction

    task automatic send_word(logic [BYTE_W-1:0] b, logic [IDX_W-1:0] ri);
        sfrwp_pkg::req_t w;
        int              gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        w.rx_byte    = b;
        w.read_index = ri;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= w;
        do @(posedge clk); while (req_stall);
        words_sent++;
    endtask

    task automatic send_frame(logic [10*BYTE_W-1:0] f, int nbytes, bit fixed_reads);
        for (int i = 0; i < nbytes; i++)
        begin
            send_word(f[10*BYTE_W-1-BYTE_W*i -: BYTE_W],
                      fixed_reads ? ((i % 2) ? 7'd127 : 7'd0) : pick_read());
        end
    endtask

    initial
    begin
        logic [10*BYTE_W-1:0] f;
        logic [WORD_W-1:0]    addr;
        int                   kind;
        int                   next_hold;
        int                   next_drain;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        hold_requests = 0;
        burst_left    = 0;
        words_sent    = 0;
        last_add      = '0;
        next_hold     = 300;
        next_drain    = 520;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // good frame at index 127 (second write wraps), checksum wraps past 16 bits
        f = make_frame(16'h007F, 16'h8000, 16'h7FFF, 1'b0);
        last_add = 7'd127;
        send_frame(f, 10, 1'b1);
        // synced frame with a bad checksum, then three bytes that fail sync
        f = make_frame(16'h0100, 16'hFFFF, 16'h0000, 1'b1);
        send_frame(f, 10, 1'b1);
        send_word(8'h00, 7'd0);
        send_word(8'hFF, 7'd127);
        send_word(8'hA5, 7'd1);

        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS)
        begin
            if (words_sent >= next_hold)
            begin
                hold_requests++;
                next_hold += 400;
            end
            if (words_sent >= next_drain)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                wait (pending == 0);
                next_drain += 400;
            end
            kind = $urandom_range(0, 99);
            addr = pick_addr();
            if (kind < 65)
            begin
                f = make_frame(addr, pick_word(), pick_word(), 1'b0);
                last_add = addr[IDX_W-1:0];
                send_frame(f, 10, 1'b0);
            end
            else if (kind < 80)
            begin
                f = make_frame(addr, pick_word(), pick_word(), 1'b1);
                send_frame(f, 10, 1'b0);
            end
            else if (kind < 90)
            begin
                // frame cut short; the rest of the stream has to resync past it
                f = make_frame(addr, pick_word(), pick_word(), 1'b0);
                send_frame(f, $urandom_range(1, 9), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_word(BYTE_W'($urandom_range(0, 255)),
                                                        pick_read());
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);

        $display("sent %0d words: %0d frames written, %0d checksum rejects, %0d results compared",
                 words_sent, good_frames, bad_sums, checked);
        $display("included long receiver hold-offs, drained pauses and truncated frames");
        if (errors == 0)
        begin
            $display("sync_framed_register_write_parser regression: pass");
        end
        else
        begin
            $display("sync_framed_register_write_parser regression: fail");
        end
        $finish;
    end

endmodule
